### src/dq_pkg.sv
// Shared types and constants for the double-ended queue.
package dq_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  localparam logic signed [VALUE_W-1:0] EMPTY_READ = 32'sh7FFF_FFFF;

  typedef enum logic [1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_BACK  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_BACK   = 2'd3
  } dq_req_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOAD
  } dq_state_t;

  // Control passed from the sequencer to the result stage.
  typedef struct packed {
    logic load;
    logic fwd_front;
    logic fwd_back;
    logic dropped;
  } dq_ctl_t;

endpackage

### src/dq_store.sv
// Entry memory: one write port and two registered read ports.
module dq_store import dq_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic signed [VALUE_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr_front,
  input  logic [AW-1:0]             raddr_back,
  output logic signed [VALUE_W-1:0] rdata_front,
  output logic signed [VALUE_W-1:0] rdata_back
);

  logic signed [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Reads return the old contents when the same entry is written in that cycle.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_front <= mem[raddr_front];
      rdata_back  <= mem[raddr_back];
    end
  end

endmodule

### src/dq_ctrl.sv
// Sequencer: head and tail indices, entry count and write forwarding.
module dq_ctrl import dq_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int CW    = 5
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                req_type,
  input  logic signed [VALUE_W-1:0] push_value,
  input  logic                      out_free,
  output logic                      mem_we,
  output logic [AW-1:0]             mem_waddr,
  output logic                      mem_re,
  output logic [AW-1:0]             mem_raddr_front,
  output logic [AW-1:0]             mem_raddr_back,
  output dq_ctl_t                   ctl,
  output logic [CW-1:0]             count,
  output logic signed [VALUE_W-1:0] fwd_value
);

  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  function automatic logic [AW-1:0] slot_next(input logic [AW-1:0] i);
    slot_next = (i == LAST) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [AW-1:0] slot_prev(input logic [AW-1:0] i);
    slot_prev = (i == '0) ? LAST : i - 1'b1;
  endfunction

  dq_state_t       state, state_next;
  logic [AW-1:0]   head, head_next;
  logic [AW-1:0]   tail, tail_next;
  logic [CW-1:0]   count_next;
  logic            fwd_front, fwd_back, dropped;
  logic            accept;
  logic            full;
  logic            is_push;
  logic            drop_now;

  assign accept  = in_valid && in_ready;
  assign full    = (count == FULL);
  assign is_push = (dq_req_t'(req_type) == REQ_PUSH_FRONT) ||
                   (dq_req_t'(req_type) == REQ_PUSH_BACK);
  assign drop_now = is_push && full;

  // Index and count update for the word being accepted.
  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    mem_we     = 1'b0;
    mem_waddr  = tail;
    case (dq_req_t'(req_type))
      REQ_PUSH_FRONT: begin
        if (!full) begin
          head_next  = slot_prev(head);
          mem_waddr  = slot_prev(head);
          mem_we     = accept;
          count_next = count + 1'b1;
        end
      end
      REQ_PUSH_BACK: begin
        if (!full) begin
          tail_next  = slot_next(tail);
          mem_we     = accept;
          count_next = count + 1'b1;
        end
      end
      REQ_POP_FRONT: begin
        if (count != '0) begin
          head_next  = slot_next(head);
          count_next = count - 1'b1;
        end
      end
      REQ_POP_BACK: begin
        if (count != '0) begin
          tail_next  = slot_prev(tail);
          count_next = count - 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign mem_re          = accept;
  assign mem_raddr_front = head_next;
  assign mem_raddr_back  = slot_prev(tail_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        head  <= head_next;
        tail  <= tail_next;
        count <= count_next;
      end
    end
  end

  // The memory read misses a write to the same entry in the same cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_value <= push_value;
      fwd_front <= mem_we && (mem_waddr == mem_raddr_front);
      fwd_back  <= mem_we && (mem_waddr == mem_raddr_back);
      dropped   <= drop_now;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    ctl.load      = 1'b0;
    ctl.fwd_front = fwd_front;
    ctl.fwd_back  = fwd_back;
    ctl.dropped   = dropped;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_LOAD: ctl.load = out_free;
      default: ;
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FULL)
    else $error("entry count above depth");

  a_accept_load: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_LOAD))
    else $error("accepted word not followed by result load");

  a_ring_ends: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == FULL) |-> (head == tail))
    else $error("head and tail disagree with count");

endmodule

### src/double_ended_queue.sv
// A request word reads the entry memory when it is accepted, and a push to the same
// entry is forwarded; the result goes to the output register once that is free.
// The queue takes no new request word until the result of the last one is loaded;
// a waiting result holds the sequencer in its load step.
// Reset clears the head and tail indices, the entry count and the handshakes;
// the entry memory is not cleared, as only occupied entries ever reach the result.
module double_ended_queue import dq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                req_type,
  input  logic signed [VALUE_W-1:0] push_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [VALUE_W-1:0] front_value,
  output logic signed [VALUE_W-1:0] back_value,
  output logic [COUNT_W-1:0]        entry_count,
  output logic                      is_empty,
  output logic                      push_dropped
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic                      mem_re;
  logic [AW-1:0]             mem_raddr_front;
  logic [AW-1:0]             mem_raddr_back;
  logic signed [VALUE_W-1:0] rdata_front;
  logic signed [VALUE_W-1:0] rdata_back;
  logic signed [VALUE_W-1:0] fwd_value;
  logic [CW-1:0]             count;
  dq_ctl_t                   ctl;
  logic                      out_free;
  logic                      empty_now;

  assign out_free  = !out_valid || out_ready;
  assign empty_now = (count == '0);

  dq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .req_type        (req_type),
    .push_value      (push_value),
    .out_free        (out_free),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_re          (mem_re),
    .mem_raddr_front (mem_raddr_front),
    .mem_raddr_back  (mem_raddr_back),
    .ctl             (ctl),
    .count           (count),
    .fwd_value       (fwd_value)
  );

  dq_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk         (clk),
    .we          (mem_we),
    .waddr       (mem_waddr),
    .wdata       (push_value),
    .re          (mem_re),
    .raddr_front (mem_raddr_front),
    .raddr_back  (mem_raddr_back),
    .rdata_front (rdata_front),
    .rdata_back  (rdata_back)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result word: an empty queue reads the largest positive value at both ends.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      if (empty_now) begin
        front_value <= EMPTY_READ;
        back_value  <= EMPTY_READ;
      end else begin
        front_value <= ctl.fwd_front ? fwd_value : rdata_front;
        back_value  <= ctl.fwd_back  ? fwd_value : rdata_back;
      end
      entry_count  <= COUNT_W'(count);
      is_empty     <= empty_now;
      push_dropped <= ctl.dropped;
    end
  end

endmodule

### tb/sv/dq_checker.sv
`timescale 1ns / 100ps
// Watches both channels of the double-ended queue, predicts each result word and compares it.
module dq_checker import dq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [1:0]                req_type,
  input  logic signed [VALUE_W-1:0] push_value,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic signed [VALUE_W-1:0] front_value,
  input  logic signed [VALUE_W-1:0] back_value,
  input  logic [COUNT_W-1:0]        entry_count,
  input  logic                      is_empty,
  input  logic                      push_dropped,
  output int                        fail_count,
  output int                        pending
);

  typedef struct {
    logic signed [VALUE_W-1:0] front;
    logic signed [VALUE_W-1:0] back;
    logic [COUNT_W-1:0]        count;
    logic                      empty;
    logic                      dropped;
  } queue_view_t;

  logic signed [VALUE_W-1:0] model_store [DEPTH];
  int unsigned model_head;
  int unsigned model_tail;
  int unsigned model_count;
  queue_view_t expected_views [$];

  function automatic int unsigned slot_after(int unsigned i);
    return (i + 1 >= DEPTH) ? 0 : i + 1;
  endfunction

  function automatic int unsigned slot_before(int unsigned i);
    return (i == 0) ? DEPTH - 1 : i - 1;
  endfunction

  // Applies one request to the shadow queue and returns the view it should report.
  function queue_view_t advance_queue(dq_req_t req, logic signed [VALUE_W-1:0] value);
    queue_view_t view;
    view.dropped = 1'b0;
    if (req == REQ_PUSH_FRONT || req == REQ_PUSH_BACK) begin
      if (model_count >= DEPTH) begin
        view.dropped = 1'b1;
      end else if (req == REQ_PUSH_FRONT) begin
        model_head = slot_before(model_head);
        model_store[model_head] = value;
        model_count++;
      end else begin
        model_store[model_tail] = value;
        model_tail = slot_after(model_tail);
        model_count++;
      end
    end else if (model_count > 0) begin
      if (req == REQ_POP_FRONT) begin
        model_head = slot_after(model_head);
      end else begin
        model_tail = slot_before(model_tail);
      end
      model_count--;
    end
    view.front = (model_count > 0) ? model_store[model_head] : EMPTY_READ;
    view.back  = (model_count > 0) ? model_store[slot_before(model_tail)] : EMPTY_READ;
    view.count = model_count[COUNT_W-1:0];
    view.empty = (model_count == 0);
    return view;
  endfunction

  task compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    queue_view_t want;
    if (rst) begin
      model_head = 0;
      model_tail = 0;
      model_count = 0;
      expected_views.delete();
      pending = 0;
    end else begin
      // The result of a word accepted on this edge cannot leave on the same edge,
      // so the output side is settled first.
      if (out_valid && out_ready) begin
        if (expected_views.size() == 0) begin
          $error("result word arrived with no request outstanding");
          fail_count++;
        end else begin
          want = expected_views.pop_front();
          compare_field("front_value", want.front, front_value);
          compare_field("back_value", want.back, back_value);
          compare_field("entry_count", want.count, entry_count);
          compare_field("is_empty", want.empty, is_empty);
          compare_field("push_dropped", want.dropped, push_dropped);
        end
      end
      if (in_valid && in_ready) begin
        expected_views.push_back(advance_queue(dq_req_t'(req_type), push_value));
      end
      pending = expected_views.size();
    end
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// Top of the double-ended queue testbench: clock, reset, request stimulus and verdict.
module testbench import dq_pkg::*;;

  localparam int DEPTH = 16;
  localparam int RANDOM_WORDS = 1350;
  localparam int IDLE_LIMIT = 2000;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  dq_req_t                   req_type = REQ_PUSH_FRONT;
  logic signed [VALUE_W-1:0] push_value = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [VALUE_W-1:0] front_value;
  logic signed [VALUE_W-1:0] back_value;
  logic [COUNT_W-1:0]        entry_count;
  logic                      is_empty;
  logic                      push_dropped;

  int fail_count;
  int pending;
  int burst_left = 0;
  int idle_cycles = 0;
  logic [7:0] ready_pattern = 8'hFF;
  int ready_ticks = 0;

  double_ended_queue #(.DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .push_value(push_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .front_value(front_value), .back_value(back_value),
    .entry_count(entry_count), .is_empty(is_empty), .push_dropped(push_dropped)
  );

  dq_checker #(.DEPTH(DEPTH)) checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .push_value(push_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .front_value(front_value), .back_value(back_value),
    .entry_count(entry_count), .is_empty(is_empty), .push_dropped(push_dropped),
    .fail_count(fail_count), .pending(pending)
  );

  always #5 clk = ~clk;

  // The receiver rotates an eight-bit ready pattern and picks a fresh one now and then.
  always @(negedge clk) begin
    if (ready_ticks == 0) begin
      ready_ticks <= 32;
      ready_pattern <= ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom);
    end else begin
      ready_ticks <= ready_ticks - 1;
      ready_pattern <= {ready_pattern[0], ready_pattern[7:1]};
    end
    out_ready <= ready_pattern[0];
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Called at a falling edge; returns at a falling edge once the word is taken, after an idle gap when a burst ends.
  task send_word(input dq_req_t req, input logic signed [VALUE_W-1:0] value);
    in_valid <= 1'b1;
    req_type <= req;
    push_value <= value;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // Some bursts are long enough to run with no gaps at all.
      burst_left = ($urandom_range(3) == 0) ? 200 : $urandom_range(1, 24);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(15))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int push_pct;
    int segment_left;
    dq_req_t req;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Pops on an empty queue, then single-entry pops from each end.
    send_word(REQ_POP_FRONT, 32'sh1234_5678);
    send_word(REQ_POP_BACK, 32'shFFFF_FFFF);
    send_word(REQ_PUSH_FRONT, 32'sh8000_0000);
    send_word(REQ_POP_BACK, '0);
    send_word(REQ_PUSH_BACK, 32'sh7FFF_FFFF);
    send_word(REQ_POP_FRONT, '0);
    // Fill to capacity from both ends, then push against a full queue.
    send_word(REQ_PUSH_FRONT, -1);
    send_word(REQ_PUSH_BACK, '0);
    for (int i = 0; i < DEPTH - 2; i++) begin
      send_word((i % 2 == 0) ? REQ_PUSH_FRONT : REQ_PUSH_BACK,
                (i % 3 == 0) ? ~(32'sh1 <<< i) : (32'sh1 <<< (i + 17)));
    end
    send_word(REQ_PUSH_FRONT, 32'sh5555_5555);
    send_word(REQ_PUSH_BACK, 32'shAAAA_AAAA);

    // Random part: segments that lean towards filling, draining or neither.
    segment_left = 0;
    push_pct = 50;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (segment_left == 0) begin
        segment_left = $urandom_range(8, 48);
        case ($urandom_range(2))
          0: push_pct = 85;
          1: push_pct = 50;
          default: push_pct = 15;
        endcase
      end
      segment_left--;
      if ($urandom_range(99) < push_pct) begin
        req = $urandom_range(1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
      end else begin
        req = $urandom_range(1) ? REQ_POP_FRONT : REQ_POP_BACK;
      end
      send_word(req, pick_value());
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
src/dq_pkg.sv
src/dq_store.sv
src/dq_ctrl.sv
src/double_ended_queue.sv
tb/sv/dq_checker.sv
tb/sv/testbench.sv
